// File: design/xterm_key_sequence_decoder_assert.svh
// Assertion macros for the key sequence decoder, used by the result queue (xkd_out_buf).
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef XTERM_KEY_SEQUENCE_DECODER_ASSERT_SVH
`define XTERM_KEY_SEQUENCE_DECODER_ASSERT_SVH

// Property that must hold at every edge outside reset.
`define XKD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define XKD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/xkd_pkg.sv
// Shared types, character codes and key tables for the key sequence decoder.
// No dependencies; the interfaces, design modules and testbench import this package.
package xkd_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 3'd0,
    KIND_META  = 3'd1,
    KIND_NAMED = 3'd2,
    KIND_FUNC  = 3'd3,
    KIND_IOERR = 3'd4,
    KIND_INVAL = 3'd5
  } key_kind_t;

  // Named key ids
  localparam logic [BYTE_W-1:0] NK_HOME   = 8'd4;
  localparam logic [BYTE_W-1:0] NK_END    = 8'd5;
  localparam logic [BYTE_W-1:0] NK_INSERT = 8'd6;
  localparam logic [BYTE_W-1:0] NK_DELETE = 8'd7;
  localparam logic [BYTE_W-1:0] NK_PGUP   = 8'd8;
  localparam logic [BYTE_W-1:0] NK_PGDN   = 8'd9;
  localparam logic [BYTE_W-1:0] NK_UNTAB  = 8'd10;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
  localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
  localparam logic [BYTE_W-1:0] CH_Z     = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  localparam logic [BYTE_W-1:0] NUM_MAX  = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              read_error;
  } rx_word_t;

  typedef struct packed {
    key_kind_t         kind;
    logic [BYTE_W-1:0] code;
  } key_word_t;

  function automatic key_word_t mk_key(key_kind_t kind, logic [BYTE_W-1:0] code);
    key_word_t k;
    k.kind = kind;
    k.code = code;
    return k;
  endfunction

  function automatic logic is_arrow(logic [BYTE_W-1:0] b);
    return (b >= CH_A) && (b <= CH_D);
  endfunction

  // Final byte after ESC O.
  function automatic key_word_t ss3_key(logic [BYTE_W-1:0] b);
    key_word_t k;
    if (is_arrow(b)) begin
      k = mk_key(KIND_NAMED, b - CH_A);
    end else if ((b >= CH_P) && (b <= CH_S)) begin
      k = mk_key(KIND_FUNC, b - CH_P + 8'd1);
    end else begin
      k = mk_key(KIND_INVAL, '0);
    end
    return k;
  endfunction

  // Number before a tilde final.
  function automatic key_word_t tilde_key(logic [BYTE_W-1:0] n);
    key_word_t k;
    unique case (n)
      8'd1:    k = mk_key(KIND_NAMED, NK_HOME);
      8'd2:    k = mk_key(KIND_NAMED, NK_INSERT);
      8'd3:    k = mk_key(KIND_NAMED, NK_DELETE);
      8'd4:    k = mk_key(KIND_NAMED, NK_END);
      8'd5:    k = mk_key(KIND_NAMED, NK_PGUP);
      8'd6:    k = mk_key(KIND_NAMED, NK_PGDN);
      8'd15:   k = mk_key(KIND_FUNC, 8'd5);
      8'd17:   k = mk_key(KIND_FUNC, 8'd6);
      8'd18:   k = mk_key(KIND_FUNC, 8'd7);
      8'd19:   k = mk_key(KIND_FUNC, 8'd8);
      8'd20:   k = mk_key(KIND_FUNC, 8'd9);
      8'd21:   k = mk_key(KIND_FUNC, 8'd10);
      8'd23:   k = mk_key(KIND_FUNC, 8'd11);
      8'd24:   k = mk_key(KIND_FUNC, 8'd12);
      default: k = mk_key(KIND_INVAL, '0);
    endcase
    return k;
  endfunction

  // Non-digit final byte after ESC [ and an optional number.
  function automatic key_word_t csi_key(logic [BYTE_W-1:0] b, logic [BYTE_W-1:0] n);
    key_word_t k;
    if (is_arrow(b)) begin
      k = mk_key(KIND_NAMED, b - CH_A);
    end else begin
      priority case (b)
        CH_F:     k = mk_key(KIND_NAMED, NK_END);
        CH_H:     k = mk_key(KIND_NAMED, NK_HOME);
        CH_Z:     k = mk_key(KIND_NAMED, NK_UNTAB);
        CH_TILDE: k = tilde_key(n);
        default:  k = mk_key(KIND_INVAL, '0);
      endcase
    end
    return k;
  endfunction

endpackage

// File: design/xkd_rx_if.sv
// Input channel: one terminal byte or a read-error event per word.
// Depends on xkd_pkg.
interface xkd_rx_if;
  import xkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              read_error;

  modport source (output valid, rx_byte, read_error, input ready);
  modport sink   (input valid, rx_byte, read_error, output ready);
endinterface

// File: design/xkd_key_if.sv
// Output channel: one decoded key event per word.
// Depends on xkd_pkg.
interface xkd_key_if;
  import xkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] key_kind;
  logic [BYTE_W-1:0] key_code;

  modport source (output valid, key_kind, key_code, input ready);
  modport sink   (input valid, key_kind, key_code, output ready);
endinterface

// File: design/xterm_key_sequence_decoder.sv
// xterm key sequence decoder: top level.
// Depends on xkd_pkg, xkd_rx_if, xkd_key_if, xkd_in_reg, xkd_decode, xkd_out_buf.
//
// Usage:
//   rx  carries one word per terminal byte: rx_byte, or read_error set when the
//       stream read failed. A word is taken on an edge where valid and ready are high.
//   key carries decoded events: key_kind (char, meta, named, function, io error,
//       invalid) and key_code. Bytes that only advance a sequence (ESC, ESC O,
//       ESC [, digits) produce no key word.
//   Path: a word taken on rx passes through the input register and then the result
//       queue before its key word shows on key.valid.
//   Throughput: one rx word per cycle, sustained while the result queue has room. Every
//       word goes through the input register and one pass of the phase/table decode.
//   Reset (synchronous, rst high) returns the parser to idle, clears the collected
//       number and empties both the input register and the result queue.
//   Stall: the two-entry result queue keeps the output side registered; when it is
//       full, decode holds its word and rx.ready drops until key.ready frees a slot.
module xterm_key_sequence_decoder (
  input  logic  clk,
  input  logic  rst,
  xkd_rx_if.sink    rx,
  xkd_key_if.source key
);
  import xkd_pkg::*;

  rx_word_t  in_word;
  rx_word_t  held_word;
  logic      held_valid;
  logic      buf_full;
  logic      advance;
  logic      res_valid;
  key_word_t res;
  key_word_t out_word;

  assign in_word.rx_byte    = rx.rx_byte;
  assign in_word.read_error = rx.read_error;

  // Decode one held word per cycle while the queue has room.
  assign advance = held_valid && !buf_full;

  xkd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_word  (in_word),
    .in_ready (rx.ready),
    .consume  (advance),
    .valid    (held_valid),
    .word     (held_word)
  );

  xkd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .word      (held_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // Push only words that actually produce a key event.
  xkd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_word (res),
    .full      (buf_full),
    .valid     (key.valid),
    .ready     (key.ready),
    .word      (out_word)
  );

  assign key.key_kind = out_word.kind;
  assign key.key_code = out_word.code;
endmodule

// File: design/xkd_in_reg.sv
// Input register stage of the key sequence decoder.
// Depends on xkd_pkg.
module xkd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  xkd_pkg::rx_word_t in_word,
  output logic              in_ready,
  input  logic              consume,
  output logic              valid,
  output xkd_pkg::rx_word_t word
);
  import xkd_pkg::*;

  // Take a new word when empty or when the held word leaves this cycle.
  assign in_ready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= in_word;
    end
  end
endmodule

// File: design/xkd_decode.sv
// Sequence parser: phase and number registers plus single-pass key decode.
// Depends on xkd_pkg.
module xkd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  xkd_pkg::rx_word_t  word,
  output logic               res_valid,
  output xkd_pkg::key_word_t res
);
  import xkd_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_SS3  = 4'b0100,
    PH_CSI  = 4'b1000
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] num, num_next;
  logic [11:0]       acc;
  logic              is_digit;

  assign is_digit = (word.rx_byte >= CH_0) && (word.rx_byte <= CH_9);
  // num * 10 + digit; the low nibble of an ASCII digit is its value
  assign acc = {1'b0, num, 3'b000} + {3'b000, num, 1'b0} + {8'd0, word.rx_byte[3:0]};

  always_comb begin
    phase_next = phase;
    num_next   = num;
    res_valid  = 1'b0;
    res        = mk_key(KIND_CHAR, word.rx_byte);
    if (word.read_error) begin
      phase_next = PH_IDLE;
      num_next   = '0;
      res_valid  = 1'b1;
      res        = mk_key(KIND_IOERR, '0);
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (word.rx_byte == CH_ESC) begin
            phase_next = PH_ESC;
          end else begin
            res_valid = 1'b1;
          end
        end
        PH_ESC: begin
          if (word.rx_byte == CH_O) begin
            phase_next = PH_SS3;
          end else if (word.rx_byte == CH_LBR) begin
            phase_next = PH_CSI;
            num_next   = '0;
          end else begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res        = mk_key(KIND_META, word.rx_byte);
          end
        end
        PH_SS3: begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          res        = ss3_key(word.rx_byte);
        end
        PH_CSI: begin
          if (is_digit) begin
            num_next = (acc > {4'd0, NUM_MAX}) ? NUM_MAX : acc[BYTE_W-1:0];
          end else begin
            phase_next = PH_IDLE;
            num_next   = '0;
            res_valid  = 1'b1;
            res        = csi_key(word.rx_byte, num);
          end
        end
        default: begin
          phase_next = PH_IDLE;
          num_next   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      num   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      num   <= num_next;
    end
  end
endmodule

// File: design/xkd_out_buf.sv
// Two-entry result queue that decouples the output handshake from decode.
// Depends on xkd_pkg and the assertion macro header.
`include "xterm_key_sequence_decoder_assert.svh"

module xkd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  xkd_pkg::key_word_t push_word,
  output logic               full,
  output logic               valid,
  input  logic               ready,
  output xkd_pkg::key_word_t word
);
  import xkd_pkg::*;

  key_word_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign pop   = valid && ready;
  assign word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  `XKD_ASSERT_ALWAYS(a_count_range, count != 2'd3, "result queue count out of range")
  `XKD_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into full result queue")
  `XKD_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 2'd1, "queue fill count lost")
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for xterm_key_sequence_decoder: feeds terminal bytes and read errors,
// predicts each decoded key word and checks the key channel in order.
// Depends on xkd_pkg, xkd_rx_if, xkd_key_if and the decoder RTL.
module testbench;
  import xkd_pkg::*;

  // Cycles with no word moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 1000;
  // Random stimulus comes in chunks; the sender drains the decoder between chunks.
  localparam int CHUNK_WORDS  = 450;
  localparam int CHUNKS       = 3;
  // One long key-side hold-off, started once this many rx words have been taken.
  localparam int HOLD_AT_WORD = 300;
  localparam int HOLD_CYCLES  = 200;
  // Quiet cycles after the last key word, to catch stray output.
  localparam int TAIL_CYCLES  = 20;

  typedef enum logic [1:0] {PH_IDLE, PH_ESC, PH_SS3, PH_CSI} seq_phase_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_TOGGLE} rdy_mode_t;

  logic clk;
  logic rst;

  xkd_rx_if  rx_ch();
  xkd_key_if key_ch();

  xterm_key_sequence_decoder dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .key(key_ch)
  );

  // Words still to be offered on rx, and key words still owed on key.
  rx_word_t  rx_backlog[$];
  key_word_t expected_keys[$];

  // Shadow of the parser state.
  seq_phase_t seq_phase = PH_IDLE;
  logic [7:0] csi_num   = '0;

  int words_queued = 0;
  int words_taken  = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  bit rx_taken     = 1'b0;

  // Sender burst/gap pacing.
  int burst_left = 8;
  int send_gap   = 0;

  // Receiver stall pattern.
  rdy_mode_t  rdy_mode  = RDY_ALWAYS;
  int         mode_left = 64;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic [7:0] rdy_tick  = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the shadow parser by one rx word. Return 1 and the key word when the word
  // completes something; return 0 for bytes that only advance a sequence.
  function automatic bit decode_expected_key(input logic [7:0] b, input logic err,
                                             output key_word_t k);
    logic [11:0] acc;
    logic [7:0]  num;
    bit          emits;
    k.kind = KIND_INVAL;
    k.code = '0;
    emits  = 1'b1;
    if (err) begin
      // A failed read aborts any sequence in flight.
      seq_phase = PH_IDLE;
      csi_num   = '0;
      k.kind    = KIND_IOERR;
    end else begin
      case (seq_phase)
        PH_IDLE: begin
          if (b == CH_ESC) begin
            seq_phase = PH_ESC;
            emits     = 1'b0;
          end else begin
            k.kind = KIND_CHAR;
            k.code = b;
          end
        end
        PH_ESC: begin
          if (b == CH_O) begin
            seq_phase = PH_SS3;
            emits     = 1'b0;
          end else if (b == CH_LBR) begin
            seq_phase = PH_CSI;
            csi_num   = '0;
            emits     = 1'b0;
          end else begin
            // Anything else after ESC, ESC itself included, is a meta character.
            seq_phase = PH_IDLE;
            k.kind    = KIND_META;
            k.code    = b;
          end
        end
        PH_SS3: begin
          seq_phase = PH_IDLE;
          if (b >= CH_A && b <= CH_D) begin
            k.kind = KIND_NAMED;
            k.code = b - CH_A;
          end else if (b >= CH_P && b <= CH_S) begin
            k.kind = KIND_FUNC;
            k.code = b - CH_P + 8'd1;
          end
        end
        default: begin
          if (b >= CH_0 && b <= CH_9) begin
            // Collect a decimal digit, saturating at the top of the byte.
            acc     = {4'd0, csi_num} * 12'd10 + {4'd0, b - CH_0};
            csi_num = (acc > 12'd255) ? NUM_MAX : acc[7:0];
            emits   = 1'b0;
          end else begin
            seq_phase = PH_IDLE;
            num       = csi_num;
            csi_num   = '0;
            if (b >= CH_A && b <= CH_D) begin
              k.kind = KIND_NAMED;
              k.code = b - CH_A;
            end else if (b == CH_F) begin
              k.kind = KIND_NAMED;
              k.code = NK_END;
            end else if (b == CH_H) begin
              k.kind = KIND_NAMED;
              k.code = NK_HOME;
            end else if (b == CH_Z) begin
              k.kind = KIND_NAMED;
              k.code = NK_UNTAB;
            end else if (b == CH_TILDE) begin
              // xterm tilde table: editing keys, then F5..F12 with gaps at 16 and 22.
              case (num)
                8'd1:  begin k.kind = KIND_NAMED; k.code = NK_HOME;   end
                8'd2:  begin k.kind = KIND_NAMED; k.code = NK_INSERT; end
                8'd3:  begin k.kind = KIND_NAMED; k.code = NK_DELETE; end
                8'd4:  begin k.kind = KIND_NAMED; k.code = NK_END;    end
                8'd5:  begin k.kind = KIND_NAMED; k.code = NK_PGUP;   end
                8'd6:  begin k.kind = KIND_NAMED; k.code = NK_PGDN;   end
                8'd15: begin k.kind = KIND_FUNC;  k.code = 8'd5;      end
                8'd17: begin k.kind = KIND_FUNC;  k.code = 8'd6;      end
                8'd18: begin k.kind = KIND_FUNC;  k.code = 8'd7;      end
                8'd19: begin k.kind = KIND_FUNC;  k.code = 8'd8;      end
                8'd20: begin k.kind = KIND_FUNC;  k.code = 8'd9;      end
                8'd21: begin k.kind = KIND_FUNC;  k.code = 8'd10;     end
                8'd23: begin k.kind = KIND_FUNC;  k.code = 8'd11;     end
                8'd24: begin k.kind = KIND_FUNC;  k.code = 8'd12;     end
                default: ;
              endcase
            end
          end
        end
      endcase
    end
    return emits;
  endfunction

  // Queue one rx word; the byte value is taken from the low eight bits of b.
  function automatic void push_word(input int b, input logic err);
    rx_word_t w;
    w.rx_byte    = 8'(b);
    w.read_error = err;
    rx_backlog.push_back(w);
    words_queued++;
  endfunction

  // Final byte of an ESC [ sequence, drawn from the finals the decoder knows.
  function automatic logic [7:0] pick_csi_final();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      4:       return CH_F;
      5:       return CH_H;
      6:       return CH_Z;
      7:       return CH_TILDE;
      default: return CH_A + r[7:0];
    endcase
  endfunction

  // Queue one random sequence: mostly well-formed xterm keys with random content,
  // the rest plain bytes, meta characters, aborted sequences and noise.
  function automatic void queue_random_sequence();
    int pick;
    int r;
    int n;
    int digits;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_word($urandom_range(0, 255), 1'b0);
    end else if (pick < 35) begin
      push_word(CH_ESC, 1'b0);
      push_word(CH_O, 1'b0);
      r = $urandom_range(0, 4);
      if (r == 0)
        push_word($urandom_range(0, 255), 1'b0);
      else if (r < 3)
        push_word(CH_A + $urandom_range(0, 3), 1'b0);
      else
        push_word(CH_P + $urandom_range(0, 3), 1'b0);
    end else if (pick < 70) begin
      push_word(CH_ESC, 1'b0);
      push_word(CH_LBR, 1'b0);
      r = $urandom_range(0, 9);
      if (r < 5) begin
        // Pick one of the fourteen numbers the tilde table knows.
        n = $urandom_range(0, 13);
        n = (n < 6) ? n + 1 : (n == 6) ? 15 : (n < 12) ? n + 10 : n + 11;
        if (n >= 10)
          push_word(CH_0 + n / 10, 1'b0);
        push_word(CH_0 + n % 10, 1'b0);
        push_word(CH_TILDE, 1'b0);
      end else if (r < 8) begin
        digits = $urandom_range(0, 2);
        repeat (digits) push_word(CH_0 + $urandom_range(0, 9), 1'b0);
        push_word(pick_csi_final(), 1'b0);
      end else if (r == 8) begin
        // Long numbers can drive the accumulator into saturation.
        digits = $urandom_range(3, 6);
        repeat (digits) push_word(CH_0 + $urandom_range(0, 9), 1'b0);
        push_word(($urandom_range(0, 1) != 0) ? CH_TILDE : pick_csi_final(), 1'b0);
      end else begin
        digits = $urandom_range(0, 1);
        repeat (digits) push_word(CH_0 + $urandom_range(0, 9), 1'b0);
        push_word($urandom_range(0, 255), 1'b0);
      end
    end else if (pick < 80) begin
      push_word(CH_ESC, 1'b0);
      push_word(($urandom_range(0, 3) == 0) ? CH_ESC : $urandom_range(0, 255), 1'b0);
    end else if (pick < 90) begin
      // Break off a sequence at a random point with a read error.
      r = $urandom_range(0, 3);
      if (r != 0)
        push_word(CH_ESC, 1'b0);
      if (r == 2)
        push_word(CH_O, 1'b0);
      if (r == 3) begin
        push_word(CH_LBR, 1'b0);
        push_word(CH_0 + $urandom_range(0, 9), 1'b0);
      end
      push_word($urandom_range(0, 255), 1'b1);
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) push_word($urandom_range(0, 255), $urandom_range(0, 7) == 0);
    end
  endfunction

  task automatic wait_drained();
    while (rx_backlog.size() != 0 || expected_keys.size() != 0) @(posedge clk);
  endtask

  // Driver: offer rx words at the falling edge, in bursts with gaps between them.
  always @(negedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
    end else if (rx_ch.valid && !rx_taken) begin
      // hold the offered word until the decoder takes it
    end else if (send_gap != 0) begin
      send_gap--;
      rx_ch.valid <= 1'b0;
    end else if (rx_backlog.size() != 0) begin
      rx_ch.valid      <= 1'b1;
      rx_ch.rx_byte    <= rx_backlog[0].rx_byte;
      rx_ch.read_error <= rx_backlog[0].read_error;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        // Roughly one burst in four runs straight into the next one.
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      end
    end else begin
      rx_ch.valid <= 1'b0;
    end
  end

  // Receiver: drive key.ready at the falling edge from a mode that changes now and then,
  // plus one long hold-off that lets the decoder fill up and push back on rx.
  always @(negedge clk) begin
    rdy_tick++;
    if (!hold_done && words_taken >= HOLD_AT_WORD) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      key_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      key_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: key_ch.ready <= 1'b1;
        RDY_COIN:   key_ch.ready <= ($urandom_range(0, 1) != 0);
        RDY_SPARSE: key_ch.ready <= ($urandom_range(0, 3) == 0);
        default:    key_ch.ready <= rdy_tick[2];
      endcase
    end
  end

  // Monitor: at each rising edge check a taken key word against the oldest expectation,
  // then predict from a taken rx word. The key check comes first so that a stray key word
  // is never matched against a prediction made in the same cycle.
  always @(posedge clk) begin : check_words
    key_word_t want;
    key_word_t next_key;
    rx_taken = 1'b0;
    if (!rst) begin
      if (key_ch.valid && key_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: key word with none expected: kind %0d code %0h",
                   $time, key_ch.key_kind, key_ch.key_code);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          if (key_ch.key_kind !== want.kind) begin
            $display("%0t: key_kind expected %0d got %0d", $time, want.kind, key_ch.key_kind);
            mismatches++;
          end
          if (key_ch.key_code !== want.code) begin
            $display("%0t: key_code expected %0h got %0h", $time, want.code, key_ch.key_code);
            mismatches++;
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        rx_taken = 1'b1;
        words_taken++;
        void'(rx_backlog.pop_front());
        if (decode_expected_key(rx_ch.rx_byte, rx_ch.read_error, next_key))
          expected_keys.push_back(next_key);
      end
      // Watchdog: count cycles in which nothing moves on either channel.
      if (rx_taken || (key_ch.valid && key_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int chunk_end;
    rx_ch.valid      = 1'b0;
    rx_ch.rx_byte    = '0;
    rx_ch.read_error = 1'b0;
    key_ch.ready     = 1'b0;
    rst              = 1'b1;

    // Directed words: byte extremes as plain characters.
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    // ESC O A: up arrow.
    push_word(CH_ESC, 1'b0);
    push_word(CH_O, 1'b0);
    push_word(CH_A, 1'b0);
    // ESC O with an unknown letter: invalid.
    push_word(CH_ESC, 1'b0);
    push_word(CH_O, 1'b0);
    push_word(CH_Z, 1'b0);
    // ESC [ 24 ~: F12, the top of the tilde table.
    push_word(CH_ESC, 1'b0);
    push_word(CH_LBR, 1'b0);
    push_word(CH_0 + 8'd2, 1'b0);
    push_word(CH_0 + 8'd4, 1'b0);
    push_word(CH_TILDE, 1'b0);
    // ESC [ 999 ~: number saturates and matches nothing.
    push_word(CH_ESC, 1'b0);
    push_word(CH_LBR, 1'b0);
    push_word(CH_9, 1'b0);
    push_word(CH_9, 1'b0);
    push_word(CH_9, 1'b0);
    push_word(CH_TILDE, 1'b0);
    // ESC [ with an unknown final: invalid.
    push_word(CH_ESC, 1'b0);
    push_word(CH_LBR, 1'b0);
    push_word(CH_O, 1'b0);
    // ESC ESC: meta ESC.
    push_word(CH_ESC, 1'b0);
    push_word(CH_ESC, 1'b0);
    // Lone ESC cut off by a read error.
    push_word(CH_ESC, 1'b0);
    push_word(8'hFF, 1'b1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    wait_drained();

    // Random chunks; the sender pauses for a full drain after each one.
    for (int c = 0; c < CHUNKS; c++) begin
      chunk_end = words_queued + CHUNK_WORDS;
      while (words_queued < chunk_end) queue_random_sequence();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/xkd_pkg.sv
design/xkd_rx_if.sv
design/xkd_key_if.sv
design/xkd_in_reg.sv
design/xkd_decode.sv
design/xkd_out_buf.sv
design/xterm_key_sequence_decoder.sv
test/testbench.sv
